/* hw/rtl/rrrt_pkg.sv */
// ----------------------------------------------------------------------------
// rrrt_pkg
// Types and constants shared by the repeat request rate table.
// ----------------------------------------------------------------------------
package rrrt_pkg;

    localparam int PID_W    = 22;
    localparam int START_W  = 64;
    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 48;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int WINDOW_W = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_LIMIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS = 2'd1;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT_RESET    = 16'd100;
    localparam logic [WINDOW_W-1:0] WINDOW_SECONDS_RESET = 8'd1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX            = 16'hFFFF;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [START_W-1:0] start;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   length;
        logic [COUNT_W-1:0] count;
        logic               reported;
        logic [TIME_W-1:0]  alloc_time;
        logic [TIME_W-1:0]  check_time;
    } slot_rec_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [START_W-1:0] start;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   length;
        logic [TIME_W-1:0]  now;
    } req_t;

    typedef struct packed {
        logic match;
        logic alarm;
    } upd_stat_t;

endpackage

/* hw/rtl/rrrt_if.sv */
// ----------------------------------------------------------------------------
// rrrt_if
// Valid/ready channels for request events and alarm results.
// ----------------------------------------------------------------------------
interface rrrt_req_if;
    logic                         valid;
    logic                         ready;
    logic [rrrt_pkg::PID_W-1:0]   process_id;
    logic [rrrt_pkg::START_W-1:0] process_start;
    logic [rrrt_pkg::ADDR_W-1:0]  region_addr;
    logic [rrrt_pkg::LEN_W-1:0]   region_length;
    logic [rrrt_pkg::TIME_W-1:0]  now_seconds;

    modport source (output valid, process_id, process_start, region_addr,
                    region_length, now_seconds, input ready);
    modport sink (input valid, process_id, process_start, region_addr,
                  region_length, now_seconds, output ready);
endinterface

interface rrrt_res_if;
    logic valid;
    logic ready;
    logic alarm;

    modport source (output valid, alarm, input ready);
    modport sink (input valid, alarm, output ready);
endinterface

/* hw/rtl/rrrt_cell.sv */
// ----------------------------------------------------------------------------
// rrrt_cell
// One slot of the table: shifts towards the head or takes a replacement.
// ----------------------------------------------------------------------------
module rrrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic                wr_en,
    input  rrrt_pkg::slot_rec_t shift_in,
    input  rrrt_pkg::slot_rec_t wr_rec,
    output rrrt_pkg::slot_rec_t rec
);

    rrrt_pkg::slot_rec_t rec_reg;
    rrrt_pkg::slot_rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (shift_en)
        begin
            rec_next = shift_in;
        end
        else if (wr_en)
        begin
            rec_next = wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

/* hw/rtl/rrrt_slot_update.sv */
// ----------------------------------------------------------------------------
// rrrt_slot_update
// Match test and counting rule applied to the slot at the head of the chain.
// ----------------------------------------------------------------------------
module rrrt_slot_update (
    input  rrrt_pkg::slot_rec_t                 rec,
    input  rrrt_pkg::req_t                      req,
    input  logic [rrrt_pkg::COUNT_W-1:0]        count_limit,
    input  logic [rrrt_pkg::WINDOW_W-1:0]       window_seconds,
    output rrrt_pkg::slot_rec_t                 upd_rec,
    output rrrt_pkg::upd_stat_t                 stat
);

    logic [rrrt_pkg::COUNT_W-1:0] count_inc;
    logic [rrrt_pkg::TIME_W-1:0]  elapsed;
    logic                         region_same;

    assign region_same = (rec.addr == req.addr) && (rec.length == req.length);
    assign count_inc   = (rec.count == rrrt_pkg::COUNT_MAX) ? rec.count
                                                            : rec.count + 1'b1;
    // A clock that went backwards counts as no time elapsed.
    assign elapsed     = (req.now >= rec.check_time) ? req.now - rec.check_time
                                                     : '0;

    always_comb
    begin
        upd_rec    = rec;
        stat.match = (rec.pid == req.pid) && (rec.start == req.start);
        stat.alarm = 1'b0;
        if (!rec.reported)
        begin
            if (!region_same)
            begin
                upd_rec.addr       = req.addr;
                upd_rec.length     = req.length;
                upd_rec.check_time = req.now;
                upd_rec.count      = '0;
            end
            else if (count_inc > count_limit)
            begin
                if (elapsed <= {{(rrrt_pkg::TIME_W-rrrt_pkg::WINDOW_W){1'b0}},
                                window_seconds})
                begin
                    upd_rec.count    = count_inc;
                    upd_rec.reported = 1'b1;
                    stat.alarm       = 1'b1;
                end
                else
                begin
                    upd_rec.check_time = req.now;
                    upd_rec.count      = '0;
                end
            end
            else
            begin
                upd_rec.count = count_inc;
            end
        end
    end

endmodule

/* hw/rtl/repeat_request_rate_table.sv */
// ----------------------------------------------------------------------------
// repeat_request_rate_table
// Burst detector for repeated region requests over a rotating slot table.
// ----------------------------------------------------------------------------
// Request events arrive on the req channel and each one produces exactly one
// transaction on the res channel, whose alarm bit is set when the event
// completes a too-fast burst. The user must write the two registers, count
// limit and window in seconds, through cfg_we, cfg_index and cfg_data only
// while idle; the block does not enforce it. Other indexes are ignored.
// The slots form a ring of cells that rotates by one place per cycle while
// scanning, so every slot passes the update logic at the head once per
// event. An event is accepted in IDLE, rotates the full ring in SCAN and
// then moves to DONE, where a replacement is written into the oldest slot
// if no slot matched and the result is registered. A new event is accepted
// only after the previous one has left DONE for IDLE.
// The result sits in an output register; a stalled receiver does not block
// the next acceptance, only the hand-over of the following result and with
// it the acceptance after that.
// Reset clears every slot to zero and restores the register defaults.
// ----------------------------------------------------------------------------
module repeat_request_rate_table #(
    parameter int SLOTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rrrt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rrrt_pkg::CFG_DATA_W-1:0]   cfg_data,
    rrrt_req_if.sink                          req,
    rrrt_res_if.source                        res
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [IDX_W-1:0]                  step_reg, step_next;
    logic                              found_reg, found_next;
    logic                              hit_alarm_reg, hit_alarm_next;
    logic [IDX_W-1:0]                  oldest_idx_reg, oldest_idx_next;
    logic [rrrt_pkg::TIME_W-1:0]       oldest_time_reg, oldest_time_next;
    logic                              res_valid_reg, res_valid_next;
    logic                              res_alarm_reg, res_alarm_next;
    logic [rrrt_pkg::COUNT_W-1:0]      count_limit_reg;
    logic [rrrt_pkg::WINDOW_W-1:0]     window_reg;
    rrrt_pkg::req_t                    req_reg;

    rrrt_pkg::slot_rec_t               cell_rec [SLOTS];
    rrrt_pkg::slot_rec_t               head_rec;
    rrrt_pkg::slot_rec_t               upd_rec;
    rrrt_pkg::slot_rec_t               tail_rec;
    rrrt_pkg::slot_rec_t               new_rec;
    rrrt_pkg::upd_stat_t               upd_stat;
    logic                              in_fire;
    logic                              shift_en;
    logic                              hit;
    logic                              deliver;

    assign in_fire  = req.valid && req.ready;
    assign shift_en = (state_reg == ST_SCAN);
    assign head_rec = cell_rec[0];
    assign hit      = shift_en && upd_stat.match && !found_reg;
    assign tail_rec = hit ? upd_rec : head_rec;
    assign deliver  = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    always_comb
    begin
        new_rec            = '0;
        new_rec.pid        = req_reg.pid;
        new_rec.start      = req_reg.start;
        new_rec.addr       = req_reg.addr;
        new_rec.length     = req_reg.length;
        new_rec.alloc_time = req_reg.now;
        new_rec.check_time = req_reg.now;
    end

    rrrt_slot_update u_update (
        .rec            (head_rec),
        .req            (req_reg),
        .count_limit    (count_limit_reg),
        .window_seconds (window_reg),
        .upd_rec        (upd_rec),
        .stat           (upd_stat)
    );

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        rrrt_pkg::slot_rec_t shift_in;
        logic                wr_en;

        if (k == SLOTS - 1)
        begin : g_tail
            assign shift_in = tail_rec;
        end
        else
        begin : g_mid
            assign shift_in = cell_rec[k+1];
        end

        // The ring is back in place during DONE, so slot k sits in cell k.
        assign wr_en = (state_reg == ST_DONE) && !found_reg
                       && (oldest_idx_reg == IDX_W'(k));

        rrrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .wr_en    (wr_en),
            .shift_in (shift_in),
            .wr_rec   (new_rec),
            .rec      (cell_rec[k])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        found_next       = found_reg;
        hit_alarm_next   = hit_alarm_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_time_next = oldest_time_reg;
        res_valid_next   = res_valid_reg;
        res_alarm_next   = res_alarm_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next     = ST_SCAN;
                    step_next      = '0;
                    found_next     = 1'b0;
                    hit_alarm_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // The first slot seeds the search; later ones replace it only
                // when strictly older, which keeps the lowest index on ties.
                if (step_reg == '0 || head_rec.alloc_time < oldest_time_reg)
                begin
                    oldest_time_next = head_rec.alloc_time;
                    oldest_idx_next  = step_reg;
                end
                if (hit)
                begin
                    found_next     = 1'b1;
                    hit_alarm_next = upd_stat.alarm;
                end
                if (step_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (deliver)
                begin
                    res_valid_next = 1'b1;
                    res_alarm_next = hit_alarm_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            found_reg       <= 1'b0;
            hit_alarm_reg   <= 1'b0;
            oldest_idx_reg  <= '0;
            oldest_time_reg <= '0;
            res_valid_reg   <= 1'b0;
            res_alarm_reg   <= 1'b0;
            count_limit_reg <= rrrt_pkg::COUNT_LIMIT_RESET;
            window_reg      <= rrrt_pkg::WINDOW_SECONDS_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            found_reg       <= found_next;
            hit_alarm_reg   <= hit_alarm_next;
            oldest_idx_reg  <= oldest_idx_next;
            oldest_time_reg <= oldest_time_next;
            res_valid_reg   <= res_valid_next;
            res_alarm_reg   <= res_alarm_next;
            if (cfg_we)
            begin
                if (cfg_index == rrrt_pkg::CFG_COUNT_LIMIT)
                begin
                    count_limit_reg <= cfg_data;
                end
                else if (cfg_index == rrrt_pkg::CFG_WINDOW_SECONDS)
                begin
                    window_reg <= cfg_data[rrrt_pkg::WINDOW_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg.pid    <= req.process_id;
            req_reg.start  <= req.process_start;
            req_reg.addr   <= req.region_addr;
            req_reg.length <= req.region_length;
            req_reg.now    <= req.now_seconds;
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = res_valid_reg;
    assign res.alarm = res_alarm_reg;

    // An accepted event always starts a fresh rotation at slot zero.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SCAN) && (step_reg == '0) && !found_reg)
        else $error("event accepted without a fresh rotation");

    // The rotation ends at the step for the last slot.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (step_reg == LAST_IDX) |=> (state_reg == ST_DONE))
        else $error("rotation did not end after the last slot");

    // An alarm can only come from a slot that matched the event.
    a_alarm_found: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) && res_alarm_reg |-> found_reg)
        else $error("alarm raised without a matching slot");

endmodule
